>>> rtl/rats_pkg.sv
`default_nettype none
package rats_pkg;
  localparam int unsigned BucketSize  = 256;
  localparam int unsigned BucketCount = 16;
  localparam int unsigned Capacity    = BucketSize * BucketCount;
  localparam int unsigned OffW        = $clog2(BucketSize);
  localparam int unsigned BktW        = (BucketCount > 1) ? $clog2(BucketCount) : 1;
  localparam int unsigned AddrW       = $clog2(Capacity);
  localparam int unsigned ElemW       = 16;
  localparam int unsigned TotW        = 28;
  localparam int unsigned BTotW       = 24;
  localparam int unsigned LenW        = 13;
  localparam int unsigned IdxW        = 13;
  localparam int unsigned ReadW       = 12;
  localparam logic        KindAssign  = 1'b0;
  localparam logic        KindRead    = 1'b1;
endpackage
`default_nettype wire

>>> rtl/rats_ram.sv
`default_nettype none
module rats_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/range_assign_total_sum_store.sv
`default_nettype none
// Range-assign / total-sum store. The block keeps 4096 signed 16-bit elements
// in one synchronous element memory, split into 16 buckets of 256 elements;
// each bucket has a running sum, a lazy fill tag and a tag valid bit held in
// flip-flops. An assign request tags whole buckets and walks partial buckets
// one element at a time through a read-modify-write on the element memory,
// after pushing a pending tag down through the whole bucket. A read request
// returns one element. Every result carries the sum of all elements in use,
// formed over the buckets one per cycle; a partial last bucket without a tag
// is summed element by element from the memory. The slowest request pushes
// and walks two partial buckets of 255 elements and sums a partial last
// bucket; the single element memory port sets its speed. After reset the
// element memory is cleared while no request is taken; configuration writes
// are accepted at any time and apply from the next request on.
module range_assign_total_sum_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rats_pkg::LenW-1:0]     length_in_use_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic signed [rats_pkg::IdxW-1:0] range_start_i,
  input  wire logic signed [rats_pkg::IdxW-1:0] range_end_i,
  input  wire logic signed [rats_pkg::ElemW-1:0] fill_value_i,
  input  wire logic [rats_pkg::ReadW-1:0]    read_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [rats_pkg::TotW-1:0]   total_sum_o,
  output logic signed [rats_pkg::ElemW-1:0]  element_value_o
);
  import rats_pkg::*;

  localparam int unsigned ReadSpan = 1 << ReadW;
  localparam int unsigned ReadWrap = Capacity % ReadSpan;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PLAN, S_SEG, S_PUSH, S_WALK_RD, S_WALK_WR,
    S_READ_RD, S_READ_WT, S_SUM, S_SUMP_RD, S_SUMP_WT, S_DONE
  } state_e;

  state_e state_q;
  logic [LenW-1:0] len_q;
  logic signed [BTotW-1:0] btot_q [BucketCount];
  logic signed [ElemW-1:0] tag_q [BucketCount];
  logic [BucketCount-1:0] tagv_q;

  // request latch
  logic kind_q;
  logic [IdxW-1:0] hi_q;         // clamped range end, nonnegative
  logic signed [ElemW-1:0] val_q;
  logic [ReadW-1:0] ridx_q;
  // segment walk: current segment [cur_q..segend] restricted to a bucket
  logic [IdxW-1:0] cur_q;        // current element / segment start
  logic [AddrW:0] ptr_q;         // memory pointer / counter
  logic [OffW:0] cnt_q;          // push counter
  logic [BktW:0] sb_q;           // sum bucket index
  logic signed [TotW-1:0] acc_q;
  logic signed [ElemW-1:0] elem_q;
  logic [LenW-1:0] ulen_q;       // used length snapshot
  logic [OffW:0] pcnt_q;         // partial bucket count

  // memory
  logic mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [ElemW-1:0] mem_wd, mem_rd;

  rats_ram #(.Width(ElemW), .Depth(Capacity)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  // combinational helpers
  logic [LenW-1:0] ulen_c;
  assign ulen_c = (len_q > LenW'(Capacity)) ? LenW'(Capacity) : len_q;

  logic [BktW-1:0] cb;
  logic [OffW-1:0] coff;
  logic [IdxW-1:0] bend;         // last index of current bucket
  logic [IdxW-1:0] segend;
  assign cb   = BktW'(cur_q >> OffW);
  assign coff = cur_q[OffW-1:0];
  assign bend = IdxW'({cur_q >> OffW, {OffW{1'b1}}});
  assign segend = (hi_q < bend) ? hi_q : bend;

  logic [BktW-1:0] wb;
  assign wb = BktW'(ptr_q[AddrW-1:0] >> OffW);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_q[AddrW-1:0];
    mem_wd = val_q;
    mem_ra = ptr_q[AddrW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      S_PUSH: begin
        mem_we = 1'b1;
        mem_wd = tag_q[cb];
        mem_wa = AddrW'({cur_q >> OffW, cnt_q[OffW-1:0]});
      end
      S_WALK_WR: mem_we = 1'b1;
      S_READ_RD: mem_ra = AddrW'(ridx_q);
      default: ;
    endcase
  end

  logic signed [IdxW:0] lo_c, hi_c;
  always_comb begin
    lo_c = (range_start_i < 0) ? '0 : (IdxW+1)'(range_start_i);
    hi_c = ((IdxW+1)'(range_end_i) > $signed({1'b0, ulen_c}) - 1)
           ? (IdxW+1)'($signed({1'b0, ulen_c}) - 1) : (IdxW+1)'(range_end_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      len_q   <= LenW'(4096);
      tagv_q  <= '0;
      for (int i = 0; i < BucketCount; i++) begin
        btot_q[i] <= '0;
        tag_q[i]  <= '0;
      end
      ptr_q <= '0;
      out_valid_o <= 1'b0;
      kind_q <= KindAssign;
      hi_q   <= '0;
      val_q  <= '0;
      ridx_q <= '0;
      cur_q  <= '0;
      cnt_q  <= '0;
      sb_q   <= '0;
      acc_q  <= '0;
      elem_q <= '0;
      ulen_q <= '0;
      pcnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        len_q <= length_in_use_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == (AddrW+1)'(Capacity - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= kind_i;
            val_q  <= fill_value_i;
            ridx_q <= read_index_i;
            ulen_q <= ulen_c;
            if (kind_i == KindRead) begin
              state_q <= S_READ_RD;
            end else if (lo_c > hi_c) begin
              acc_q <= '0; sb_q <= '0; state_q <= S_SUM;
            end else begin
              hi_q <= IdxW'(hi_c);
              cur_q <= IdxW'(lo_c);
              state_q <= S_SEG;
            end
          end
        end
        S_SEG: begin
          // one bucket segment [cur_q..segend]
          if (coff == '0 && segend == bend) begin
            tag_q[cb]  <= val_q;
            tagv_q[cb] <= 1'b1;
            if (segend == hi_q) begin
              acc_q <= '0; sb_q <= '0; state_q <= S_SUM;
            end else cur_q <= segend + 1'b1;
          end else if (tagv_q[cb]) begin
            cnt_q <= '0;
            state_q <= S_PUSH;
          end else begin
            ptr_q <= (AddrW+1)'(cur_q);
            state_q <= S_WALK_RD;
          end
        end
        S_PUSH: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (OffW+1)'(BucketSize - 1)) begin
            tagv_q[cb] <= 1'b0;
            btot_q[cb] <= BTotW'(tag_q[cb] * $signed(BTotW'(BucketSize)));
            ptr_q <= (AddrW+1)'(cur_q);
            state_q <= S_WALK_RD;
          end
        end
        S_WALK_RD: state_q <= S_PLAN; // read data arrives next cycle
        S_PLAN: state_q <= S_WALK_WR;
        S_WALK_WR: begin
          btot_q[wb] <= btot_q[wb] + BTotW'(val_q) - BTotW'($signed(mem_rd));
          if (ptr_q[AddrW-1:0] == AddrW'(segend)) begin
            if (segend == hi_q) begin
              acc_q <= '0; sb_q <= '0; state_q <= S_SUM;
            end else begin
              cur_q <= segend + 1'b1;
              state_q <= S_SEG;
            end
          end else begin
            ptr_q <= ptr_q + 1'b1;
            state_q <= S_WALK_RD;
          end
        end
        S_READ_RD: state_q <= S_READ_WT;
        S_READ_WT: begin
          elem_q <= tagv_q[BktW'(ridx_q >> OffW)] ? tag_q[BktW'(ridx_q >> OffW)]
                                                 : $signed(mem_rd);
          acc_q <= '0; sb_q <= '0; state_q <= S_SUM;
        end
        S_SUM: begin
          if (sb_q == (BktW+1)'(BucketCount) ||
              (LenW+1)'(ulen_q) <= (LenW+1)'(sb_q) * (LenW+1)'(BucketSize)) begin
            state_q <= S_DONE;
            out_valid_o <= 1'b1;
          end else begin
            logic [LenW:0] rem;
            rem = (LenW+1)'(ulen_q) - (LenW+1)'(sb_q) * (LenW+1)'(BucketSize);
            if (rem >= (LenW+1)'(BucketSize)) begin
              acc_q <= acc_q + (tagv_q[sb_q[BktW-1:0]]
                 ? TotW'(tag_q[sb_q[BktW-1:0]]) * $signed(TotW'(BucketSize))
                 : TotW'(btot_q[sb_q[BktW-1:0]]));
              sb_q <= sb_q + 1'b1;
            end else if (tagv_q[sb_q[BktW-1:0]]) begin
              acc_q <= acc_q + TotW'(tag_q[sb_q[BktW-1:0]]) *
                               TotW'($signed({1'b0, rem}));
              sb_q <= sb_q + 1'b1;
            end else begin
              pcnt_q <= (OffW+1)'(rem);
              ptr_q  <= (AddrW+1)'(sb_q) << OffW;
              state_q <= S_SUMP_RD;
            end
          end
        end
        S_SUMP_RD: begin
          ptr_q <= ptr_q + 1'b1;
          pcnt_q <= pcnt_q - 1'b1;
          state_q <= S_SUMP_WT;
        end
        S_SUMP_WT: begin
          acc_q <= acc_q + TotW'($signed(mem_rd));
          if (pcnt_q == '0) begin
            state_q <= S_DONE;
            out_valid_o <= 1'b1;
          end else state_q <= S_SUMP_RD;
        end
        S_DONE: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign total_sum_o     = acc_q;
  assign element_value_o = (kind_q == KindRead &&
                            (Capacity >= ReadSpan || ridx_q < ReadW'(ReadWrap)))
                           ? elem_q : '0;

  // Results appear only from the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_DONE) else $error("result outside done");
  // No request is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken during result");
  // A taken result frees the block next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> in_ready_o) else $error("no return to idle");
endmodule
`default_nettype wire

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rats_pkg::*;

  // Clock and reset. Reset is held low at the start of the run only.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // Inputs of the block. Every one of them has a known value from time zero.
  logic                    cfg_valid_i = 1'b0;
  logic [LenW-1:0]         length_in_use_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    kind_i = KindAssign;
  logic signed [IdxW-1:0]  range_start_i = '0;
  logic signed [IdxW-1:0]  range_end_i = '0;
  logic signed [ElemW-1:0] fill_value_i = '0;
  logic [ReadW-1:0]        read_index_i = '0;
  logic                    out_ready_i = 1'b0;

  // Outputs of the block.
  logic                    cfg_ready_o;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic signed [TotW-1:0]  total_sum_o;
  logic signed [ElemW-1:0] element_value_o;

  range_assign_total_sum_store dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .length_in_use_i,
    .in_valid_i, .in_ready_o, .kind_i, .range_start_i, .range_end_i,
    .fill_value_i, .read_index_i, .out_valid_o, .out_ready_i,
    .total_sum_o, .element_value_o
  );

  // Shadow copy of the store. Each element is kept flat, with no buckets and
  // no lazy tags. That gives a second, simpler view that the bucketed
  // hardware has to agree with.
  logic signed [ElemW-1:0] shadow_elem [Capacity];
  int unsigned shadow_len;

  typedef struct packed {
    logic signed [TotW-1:0]  total;
    logic signed [ElemW-1:0] elem;
  } store_result_t;

  store_result_t expected_results[$];

  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned send_idle_pct;   // Chance in percent that the sender idles a cycle.
  int unsigned recv_stall_pct;  // Chance in percent that the receiver stalls a cycle.

  // Works out the result of one request and updates the shadow store.
  // The range is clamped to the length in use. A length above capacity acts
  // as full capacity. Reads beyond capacity cannot happen with 12-bit indexes.
  function automatic store_result_t apply_request(logic k, logic signed [IdxW-1:0] rs,
                                                  logic signed [IdxW-1:0] re,
                                                  logic signed [ElemW-1:0] fv,
                                                  logic [ReadW-1:0] ri);
    int lo;
    int hi;
    int len;
    longint acc;
    store_result_t res;
    len = (shadow_len > Capacity) ? Capacity : shadow_len;
    res.elem = '0;
    if (k == KindAssign) begin
      lo = (rs < 0) ? 0 : int'(rs);
      hi = (int'(re) > len - 1) ? len - 1 : int'(re);
      for (int i = lo; i <= hi; i++) shadow_elem[i] = fv;
    end else begin
      res.elem = shadow_elem[ri];
    end
    acc = 0;
    for (int i = 0; i < len; i++) acc += shadow_elem[i];
    res.total = acc[TotW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Sends one request. Valid is raised at a clock edge and stays high, with
  // the payload unchanged, until the request has been accepted. Valid is
  // lowered when the sender idles or by drain when no request follows.
  task automatic send_request(logic k, logic signed [IdxW-1:0] rs,
                              logic signed [IdxW-1:0] re,
                              logic signed [ElemW-1:0] fv, logic [ReadW-1:0] ri);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    kind_i <= k;
    range_start_i <= rs;
    range_end_i <= re;
    fill_value_i <= fv;
    read_index_i <= ri;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.insert(expected_results.size(), apply_request(k, rs, re, fv, ri));
    requests_sent++;
  endtask

  // Result side. The stall decision is drawn at each edge. Each result is
  // checked against the oldest expected result at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", total_sum_o, 0);
        end else begin
          store_result_t want;
          want = expected_results.pop_front();
          if (total_sum_o !== want.total) report_mismatch("total_sum", total_sum_o, want.total);
          if (element_value_o !== want.elem)
            report_mismatch("element_value", element_value_o, want.elem);
        end
        results_seen++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Lowers valid, waits until every expected result has arrived, then goes on
  // clocking so that the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Writes the length register. This is only called while the block is idle.
  task automatic write_length(int unsigned len);
    drain();
    length_in_use_i <= len[LenW-1:0];
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_len = len;
  endtask

  task automatic random_request();
    int unsigned sel;
    int a;
    int b;
    sel = $urandom_range(99);
    if (sel < 30) begin
      send_request(KindRead, '0, '0, 16'($urandom), 12'($urandom));
      return;
    end
    // Most assigns are short or sit near bucket edges, so that partial walks
    // and tag pushes stay common while the run remains fast.
    a = $urandom_range(4096) - 1;
    if (sel < 55) b = a + $urandom_range(8);
    else if (sel < 80) b = ((a / BucketSize) + $urandom_range(3)) * BucketSize
                            + BucketSize - 1 - $urandom_range(2);
    else b = $urandom_range(4096) - 1;
    if (b > 4095) b = 4095;
    if (sel >= 95) begin
      // Random bits, with empty and inverted ranges possible.
      a = $urandom_range(4096) - 1;
      b = $urandom_range(4096) - 1;
    end
    send_request(KindAssign, a[IdxW-1:0], b[IdxW-1:0], 16'($urandom), 12'($urandom));
  endtask

  task automatic test_directed();
    send_request(KindRead, '0, '0, '0, 12'd0);
    send_request(KindAssign, 13'd5, 13'd5, 16'sh7fff, '0);
    send_request(KindAssign, -13'sd1, 13'd3, -16'sd32768, '0);
    send_request(KindAssign, 13'd256, 13'd511, 16'sd1234, '0);
    send_request(KindAssign, 13'd0, 13'd4095, -16'sd1, '0);
    send_request(KindAssign, 13'd300, 13'd299, 16'sd9, '0);
    send_request(KindAssign, 13'd250, 13'd770, 16'sd77, '0);
    send_request(KindAssign, 13'd4000, -13'sd1, 16'sd5, '0);
    send_request(KindAssign, 13'd4095, 13'd4095, 16'sh5555, 12'hfff);
    send_request(KindRead, '0, '0, '0, 12'hfff);
    send_request(KindRead, '0, '0, '0, 12'd260);
    send_request(KindRead, '0, '0, '0, 12'd251);
    send_request(KindRead, '0, '0, '0, 12'd4);
    send_request(KindRead, 13'h1fff, 13'h1fff, 16'hffff, 12'haaa);
  endtask

  task automatic test_lengths();
    // Partial last bucket: assigns and reads beyond the length in use.
    write_length(1000);
    send_request(KindAssign, 13'd700, 13'd2000, 16'sd300, '0);
    send_request(KindAssign, 13'd768, 13'd4095, -16'sd7, '0);
    send_request(KindRead, '0, '0, '0, 12'd3000);
    for (int i = 0; i < 30; i++) random_request();
    write_length(1);
    send_request(KindAssign, -13'sd1, 13'd4095, 16'sd11, '0);
    send_request(KindRead, '0, '0, '0, 12'd1);
    write_length(0);
    send_request(KindAssign, 13'd0, 13'd4095, 16'sd42, '0);
    send_request(KindRead, '0, '0, '0, 12'd0);
    write_length(8191);
    send_request(KindAssign, 13'd0, 13'd255, 16'sd3, '0);
    write_length(4096);
  endtask

  task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) random_request();
  endtask

  initial begin
    foreach (shadow_elem[i]) shadow_elem[i] = '0;
    shadow_len = Capacity;
    mismatch_count = 0;
    requests_sent = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_lengths();
    test_random(130, 0, 0);
    test_random(110, 69, 0);
    test_random(110, 0, 69);
    write_length(2500);
    test_random(110, 27, 27);
    write_length(4096);
    drain();
    $display("Sent %0d requests and checked %0d results across lengths 0 to 8191,",
             requests_sent, results_seen);
    $display("with idle sender, stalling receiver and mixed phases; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog. The limit covers every request at its worst case plus the clearing
  // pass after reset, and is several times the slowest correct run.
  initial begin
    #200ms;
    $display("testbench failed");
    $finish;
  end
endmodule
